[sv/iau_pkg.sv]
package iau_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic signed [31:0] CODE_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] CODE_MAX = 32'sh7FFF_FFFF;

	localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;
	localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;

	localparam int NLANE     = 4;
	localparam int DIV_STEPS = 32;
	localparam int ST_DIV0   = 2;
	localparam int ST_MUL    = 4;
	localparam int ST_FIN    = ST_DIV0 + DIV_STEPS + 1;
	localparam int ST_OUT    = ST_FIN + 1;

	typedef enum logic [3:0] {
		MODE_ADD     = 4'd0,
		MODE_SUB     = 4'd1,
		MODE_MUL     = 4'd2,
		MODE_DIV     = 4'd3,
		MODE_NEG     = 4'd4,
		MODE_CONS    = 4'd5,
		MODE_CONST   = 4'd6,
		MODE_ISECT   = 4'd7,
		MODE_CONTAIN = 4'd8,
		MODE_DISJ    = 4'd9,
		MODE_LT      = 4'd10,
		MODE_LE      = 4'd11,
		MODE_EQ      = 4'd12,
		MODE_GE      = 4'd13,
		MODE_GT      = 4'd14
	} mode_t;

	typedef struct packed {
		logic        is_mul;
		logic        is_div;
		logic [31:0] lo;
		logic [31:0] hi;
		logic        truth;
	} side_t;

	// one quotient lane of the divider
	typedef struct packed {
		logic        spec;
		logic [31:0] spec_lo;
		logic [31:0] spec_hi;
		logic        ovf;
		logic        neg;
		logic [30:0] d;
		logic [30:0] rem;
		logic [31:0] nq;
	} dlane_t;

	typedef dlane_t [NLANE-1:0] dlanes_t;

	function automatic logic [31:0] sat_wide(input logic signed [65:0] v);
		logic [31:0] r;
		if (v <= WIDE_MIN) begin
			r = CODE_MIN;
		end else if (v >= WIDE_MAX) begin
			r = CODE_MAX;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[sv/iau_front.sv]
module iau_front (
	input  logic                 clk,
	input  logic                 en,
	input  logic [3:0]           mode_s1,
	input  logic signed [31:0]   a_lo_s1,
	input  logic signed [31:0]   a_hi_s1,
	input  logic signed [31:0]   b_lo_s1,
	input  logic signed [31:0]   b_hi_s1,
	output iau_pkg::side_t       side_s2,
	output iau_pkg::dlanes_t     lanes_s2
);

	function automatic logic [31:0] add_bnd(input logic signed [31:0] x,
			input logic signed [31:0] y, input logic yneg, input logic up);
		logic              ni, pi;
		logic signed [33:0] s;
		logic [31:0]       r;
		ni = (x == iau_pkg::CODE_MIN) || (yneg ? (y == iau_pkg::CODE_MAX)
			: (y == iau_pkg::CODE_MIN));
		pi = (x == iau_pkg::CODE_MAX) || (yneg ? (y == iau_pkg::CODE_MIN)
			: (y == iau_pkg::CODE_MAX));
		s = yneg ? (34'(x) - 34'(y)) : (34'(x) + 34'(y));
		if (up && pi) begin
			r = iau_pkg::CODE_MAX;
		end else if (ni) begin
			r = iau_pkg::CODE_MIN;
		end else if (pi) begin
			r = iau_pkg::CODE_MAX;
		end else begin
			r = iau_pkg::sat_wide(66'(s));
		end
		return r;
	endfunction

	function automatic logic [31:0] neg_bnd(input logic signed [31:0] x);
		logic [31:0] r;
		if (x == iau_pkg::CODE_MIN) begin
			r = iau_pkg::CODE_MAX;
		end else if (x == iau_pkg::CODE_MAX) begin
			r = iau_pkg::CODE_MIN;
		end else begin
			r = -x;
		end
		return r;
	endfunction

	function automatic iau_pkg::dlane_t lane_init(input logic signed [31:0] x,
			input logic signed [31:0] d);
		logic           x_inf, d_inf;
		logic [30:0]    xm, dm;
		logic [63:0]    n;
		iau_pkg::dlane_t l;
		x_inf = (x == iau_pkg::CODE_MIN) || (x == iau_pkg::CODE_MAX);
		d_inf = (d == iau_pkg::CODE_MIN) || (d == iau_pkg::CODE_MAX);
		xm = x[31] ? (~x[30:0] + 31'd1) : x[30:0];
		dm = d[31] ? (~d[30:0] + 31'd1) : d[30:0];
		n = {33'd0, xm} << iau_pkg::FRAC_BITS;
		l = '0;
		l.neg = x[31] ^ d[31];
		l.d = dm;
		l.ovf = n[63:32] >= {1'b0, dm};
		l.rem = n[62:32];
		l.nq = n[31:0];
		if (x == 32'sd0) begin
			l.spec = 1'b1;
		end else if (x_inf && d_inf) begin
			l.spec = 1'b1;
			l.spec_lo = iau_pkg::CODE_MIN;
			l.spec_hi = iau_pkg::CODE_MAX;
		end else if (x_inf) begin
			l.spec = 1'b1;
			l.spec_lo = l.neg ? iau_pkg::CODE_MIN : iau_pkg::CODE_MAX;
			l.spec_hi = l.spec_lo;
		end else if (d_inf) begin
			l.spec = 1'b1;
		end
		return l;
	endfunction

	iau_pkg::side_t   side;
	iau_pkg::dlanes_t lanes;
	logic             div_zero;

	always_comb begin
		div_zero = (b_lo_s1 <= 32'sd0 && b_hi_s1 >= 32'sd0) || b_lo_s1 == 32'sd0
			|| b_hi_s1 == 32'sd0;
		side = '0;
		unique case (iau_pkg::mode_t'(mode_s1))
			iau_pkg::MODE_ADD: begin
				side.lo = add_bnd(a_lo_s1, b_lo_s1, 1'b0, 1'b0);
				side.hi = add_bnd(a_hi_s1, b_hi_s1, 1'b0, 1'b1);
			end
			iau_pkg::MODE_SUB: begin
				side.lo = add_bnd(a_lo_s1, b_hi_s1, 1'b1, 1'b0);
				side.hi = add_bnd(a_hi_s1, b_lo_s1, 1'b1, 1'b1);
			end
			iau_pkg::MODE_MUL: side.is_mul = 1'b1;
			iau_pkg::MODE_DIV: begin
				if (div_zero) begin
					side.lo = iau_pkg::CODE_MIN;
					side.hi = iau_pkg::CODE_MAX;
				end else begin
					side.is_div = 1'b1;
				end
			end
			iau_pkg::MODE_NEG: begin
				side.lo = neg_bnd(a_hi_s1);
				side.hi = neg_bnd(a_lo_s1);
			end
			iau_pkg::MODE_CONS:    side.truth = a_lo_s1 <= a_hi_s1;
			iau_pkg::MODE_CONST:   side.truth = a_lo_s1 == a_hi_s1;
			iau_pkg::MODE_ISECT:   side.truth = a_hi_s1 >= b_lo_s1 && a_lo_s1 <= b_hi_s1;
			iau_pkg::MODE_CONTAIN: side.truth = a_lo_s1 <= b_lo_s1 && a_hi_s1 >= b_hi_s1;
			iau_pkg::MODE_DISJ:    side.truth = a_hi_s1 < b_lo_s1 || a_lo_s1 > b_hi_s1;
			iau_pkg::MODE_LT:      side.truth = a_hi_s1 < b_lo_s1;
			iau_pkg::MODE_LE:      side.truth = a_hi_s1 <= b_lo_s1;
			iau_pkg::MODE_EQ:      side.truth = a_lo_s1 == a_hi_s1 && b_lo_s1 == b_hi_s1
				&& a_lo_s1 == b_lo_s1;
			iau_pkg::MODE_GE:      side.truth = a_lo_s1 >= b_hi_s1;
			iau_pkg::MODE_GT:      side.truth = a_lo_s1 > b_hi_s1;
			default:               side = '0;
		endcase
		lanes[0] = lane_init(a_lo_s1, b_lo_s1);
		lanes[1] = lane_init(a_lo_s1, b_hi_s1);
		lanes[2] = lane_init(a_hi_s1, b_lo_s1);
		lanes[3] = lane_init(a_hi_s1, b_hi_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side;
			lanes_s2 <= lanes;
		end
	end

endmodule

[sv/iau_mul.sv]
module iau_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a_lo_s1,
	input  logic signed [31:0] a_hi_s1,
	input  logic signed [31:0] b_lo_s1,
	input  logic signed [31:0] b_hi_s1,
	output logic [31:0]        lo_s4,
	output logic [31:0]        hi_s4
);

	localparam logic signed [65:0] SENT = 66'sh1_0000_0000_0000_0000;
	localparam logic signed [65:0] RND  = 66'((66'sd1 <<< iau_pkg::FRAC_BITS) - 66'sd1);

	logic signed [63:0] prod_s2 [iau_pkg::NLANE];
	logic [iau_pkg::NLANE-1:0] zero_s2, inf_s2, neg_s2;
	logic signed [65:0] mn_s3, mx_s3;

	logic signed [31:0] x [iau_pkg::NLANE];
	logic signed [31:0] y [iau_pkg::NLANE];
	logic signed [65:0] v [iau_pkg::NLANE];
	logic signed [65:0] mn01, mn23, mx01, mx23;

	always_comb begin
		for (int i = 0; i < iau_pkg::NLANE; i++) begin
			x[i] = (i < 2) ? a_lo_s1 : a_hi_s1;
			y[i] = (i % 2 == 1) ? b_hi_s1 : b_lo_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < iau_pkg::NLANE; i++) begin
				prod_s2[i] <= 64'(x[i]) * 64'(y[i]);
				zero_s2[i] <= x[i] == 32'sd0 || y[i] == 32'sd0;
				inf_s2[i] <= x[i] == iau_pkg::CODE_MIN || x[i] == iau_pkg::CODE_MAX
					|| y[i] == iau_pkg::CODE_MIN || y[i] == iau_pkg::CODE_MAX;
				neg_s2[i] <= x[i][31] ^ y[i][31];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < iau_pkg::NLANE; i++) begin
			if (zero_s2[i]) begin
				v[i] = '0;
			end else if (inf_s2[i]) begin
				v[i] = neg_s2[i] ? -SENT : SENT;
			end else begin
				v[i] = 66'(prod_s2[i]);
			end
		end
		mn01 = (v[1] < v[0]) ? v[1] : v[0];
		mn23 = (v[3] < v[2]) ? v[3] : v[2];
		mx01 = (v[1] > v[0]) ? v[1] : v[0];
		mx23 = (v[3] > v[2]) ? v[3] : v[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s3 <= (mn23 < mn01) ? mn23 : mn01;
			mx_s3 <= (mx23 > mx01) ? mx23 : mx01;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4 <= iau_pkg::sat_wide(mn_s3 >>> iau_pkg::FRAC_BITS);
			hi_s4 <= iau_pkg::sat_wide((mx_s3 + RND) >>> iau_pkg::FRAC_BITS);
		end
	end

endmodule

[sv/iau_div_step.sv]
module iau_div_step (
	input  logic              clk,
	input  logic              en,
	input  iau_pkg::dlanes_t  lanes_prev,
	output iau_pkg::dlanes_t  lanes
);

	iau_pkg::dlanes_t nxt;
	logic [31:0]      t;

	always_comb begin
		nxt = lanes_prev;
		t = '0;
		for (int i = 0; i < iau_pkg::NLANE; i++) begin
			t = {lanes_prev[i].rem, lanes_prev[i].nq[31]};
			if (t >= {1'b0, lanes_prev[i].d}) begin
				nxt[i].rem = 31'(t - {1'b0, lanes_prev[i].d});
				nxt[i].nq = {lanes_prev[i].nq[30:0], 1'b1};
			end else begin
				nxt[i].rem = t[30:0];
				nxt[i].nq = {lanes_prev[i].nq[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes <= nxt;
		end
	end

endmodule

[sv/iau_div_fin.sv]
module iau_div_fin (
	input  logic                                  clk,
	input  logic                                  en,
	input  iau_pkg::dlanes_t                      lanes,
	output logic [iau_pkg::NLANE-1:0][31:0]       lo_s35,
	output logic [iau_pkg::NLANE-1:0][31:0]       hi_s35
);

	logic [iau_pkg::NLANE-1:0][31:0] lo, hi;
	logic signed [33:0]              q, qr, vl, vh;

	always_comb begin
		q = '0;
		qr = '0;
		vl = '0;
		vh = '0;
		for (int i = 0; i < iau_pkg::NLANE; i++) begin
			q = {2'b00, lanes[i].nq};
			qr = q + 34'(lanes[i].rem != '0);
			vl = lanes[i].neg ? -qr : q;
			vh = lanes[i].neg ? -q : qr;
			if (lanes[i].spec) begin
				lo[i] = lanes[i].spec_lo;
				hi[i] = lanes[i].spec_hi;
			end else if (lanes[i].ovf) begin
				lo[i] = lanes[i].neg ? iau_pkg::CODE_MIN : iau_pkg::CODE_MAX;
				hi[i] = lo[i];
			end else begin
				lo[i] = iau_pkg::sat_wide(66'(vl));
				hi[i] = iau_pkg::sat_wide(66'(vh));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s35 <= lo;
			hi_s35 <= hi;
		end
	end

endmodule

[sv/interval_arithmetic_unit.sv]
// Interval ALU over signed Q16.16 bounds (codes 0x80000000 and 0x7FFFFFFF are
// minus and plus infinity). One beat is accepted every cycle while in_ready is
// high; every result leaves in order, for all operations alike. The longest
// path is the divider, built of four restoring quotient lanes that form one
// quotient bit per stage over 32 stages. The multiplier takes three stages and
// the simple operations one; their results ride a delay line alongside.
// in_ready drops only when the output register holds a beat that is not taken.
module interval_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         mode,
	input  logic signed [31:0] a_lo,
	input  logic signed [31:0] a_hi,
	input  logic signed [31:0] b_lo,
	input  logic signed [31:0] b_hi,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_lo,
	output logic signed [31:0] res_hi,
	output logic               truth
);

	localparam int NL = iau_pkg::NLANE;

	logic en;
	logic valid_s [1:iau_pkg::ST_OUT];

	logic [3:0]         mode_s1;
	logic signed [31:0] a_lo_s1, a_hi_s1, b_lo_s1, b_hi_s1;

	iau_pkg::side_t   side_s2;
	iau_pkg::side_t   side_s [iau_pkg::ST_DIV0+1:iau_pkg::ST_FIN];
	iau_pkg::side_t   merged;
	iau_pkg::dlanes_t div_s [iau_pkg::ST_DIV0:iau_pkg::ST_DIV0+iau_pkg::DIV_STEPS];

	logic [31:0]              mul_lo_s4, mul_hi_s4;
	logic [NL-1:0][31:0]      dlo_s35, dhi_s35;
	logic signed [31:0]       dmin, dmax;

	logic signed [31:0] res_lo_s36, res_hi_s36;
	logic               truth_s36;

	assign en = !valid_s[iau_pkg::ST_OUT] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= iau_pkg::ST_OUT; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[1] <= in_valid;
			for (int k = 2; k <= iau_pkg::ST_OUT; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			a_lo_s1 <= a_lo;
			a_hi_s1 <= a_hi;
			b_lo_s1 <= b_lo;
			b_hi_s1 <= b_hi;
		end
	end

	iau_front u_front (
		.clk      (clk),
		.en       (en),
		.mode_s1  (mode_s1),
		.a_lo_s1  (a_lo_s1),
		.a_hi_s1  (a_hi_s1),
		.b_lo_s1  (b_lo_s1),
		.b_hi_s1  (b_hi_s1),
		.side_s2  (side_s2),
		.lanes_s2 (div_s[iau_pkg::ST_DIV0])
	);

	iau_mul u_mul (
		.clk     (clk),
		.en      (en),
		.a_lo_s1 (a_lo_s1),
		.a_hi_s1 (a_hi_s1),
		.b_lo_s1 (b_lo_s1),
		.b_hi_s1 (b_hi_s1),
		.lo_s4   (mul_lo_s4),
		.hi_s4   (mul_hi_s4)
	);

	// product bounds join the delay line after the multiplier stage
	always_comb begin
		merged = side_s[iau_pkg::ST_MUL];
		if (merged.is_mul) begin
			merged.lo = mul_lo_s4;
			merged.hi = mul_hi_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[iau_pkg::ST_DIV0+1] <= side_s2;
			for (int k = iau_pkg::ST_DIV0 + 2; k <= iau_pkg::ST_FIN; k++) begin
				if (k == iau_pkg::ST_MUL + 1) begin
					side_s[k] <= merged;
				end else begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	for (genvar k = 1; k <= iau_pkg::DIV_STEPS; k++) begin : g_step
		iau_div_step u_step (
			.clk        (clk),
			.en         (en),
			.lanes_prev (div_s[iau_pkg::ST_DIV0+k-1]),
			.lanes      (div_s[iau_pkg::ST_DIV0+k])
		);
	end

	iau_div_fin u_fin (
		.clk    (clk),
		.en     (en),
		.lanes  (div_s[iau_pkg::ST_DIV0+iau_pkg::DIV_STEPS]),
		.lo_s35 (dlo_s35),
		.hi_s35 (dhi_s35)
	);

	always_comb begin
		dmin = $signed(dlo_s35[0]);
		dmax = $signed(dhi_s35[0]);
		for (int i = 1; i < NL; i++) begin
			if ($signed(dlo_s35[i]) < dmin) begin
				dmin = $signed(dlo_s35[i]);
			end
			if ($signed(dhi_s35[i]) > dmax) begin
				dmax = $signed(dhi_s35[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			truth_s36 <= side_s[iau_pkg::ST_FIN].truth;
			if (side_s[iau_pkg::ST_FIN].is_div) begin
				res_lo_s36 <= dmin;
				res_hi_s36 <= dmax;
			end else begin
				res_lo_s36 <= side_s[iau_pkg::ST_FIN].lo;
				res_hi_s36 <= side_s[iau_pkg::ST_FIN].hi;
			end
		end
	end

	assign out_valid = valid_s[iau_pkg::ST_OUT];
	assign res_lo = res_lo_s36;
	assign res_hi = res_hi_s36;
	assign truth = truth_s36;

endmodule

[dv/interval_arithmetic_unit_test.sv]
module interval_arithmetic_unit_test;

	localparam logic signed [31:0] NINF = 32'sh8000_0000;
	localparam logic signed [31:0] PINF = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam int LATENCY = 40;

	typedef struct {
		logic [3:0] mode;
		logic signed [31:0] al, ah, bl, bh;
	} op_beat_t;

	typedef struct {
		logic signed [31:0] lo, hi;
		logic truth;
	} interval_res_t;

	typedef struct {
		op_beat_t op;
		bit known;
		interval_res_t res;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] mode = '0;
	logic signed [31:0] a_lo = '0, a_hi = '0, b_lo = '0, b_hi = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] res_lo, res_hi;
	logic truth;

	interval_res_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 80;
	bit hold_off = 1'b0;

	interval_arithmetic_unit dut (.*);

	always #10 clk = ~clk;

	// extended values: infinities as 64-bit extremes
	localparam longint XNINF = 64'sh8000_0000_0000_0000;
	localparam longint XPINF = 64'sh7FFF_FFFF_FFFF_FFFF;

	function automatic longint widen(logic signed [31:0] r);
		if (r == NINF) return XNINF;
		if (r == PINF) return XPINF;
		return longint'(r);
	endfunction

	function automatic bit infinite(longint v);
		return v == XNINF || v == XPINF;
	endfunction

	function automatic logic signed [31:0] clamp(longint v);
		if (v <= longint'(NINF)) return NINF;
		if (v >= longint'(PINF)) return PINF;
		return v[31:0];
	endfunction

	function automatic longint negx(longint x);
		if (x == XNINF) return XPINF;
		if (x == XPINF) return XNINF;
		return -x;
	endfunction

	function automatic longint addx(longint x, longint y, bit up);
		if ((x == XNINF && y == XPINF) || (x == XPINF && y == XNINF))
			return up ? XPINF : XNINF;
		if (x == XNINF || y == XNINF) return XNINF;
		if (x == XPINF || y == XPINF) return XPINF;
		return x + y;
	endfunction

	function automatic longint mulx(longint x, longint y);
		if (x == 0 || y == 0) return 0;
		if (infinite(x) || infinite(y)) return ((x < 0) != (y < 0)) ? XNINF : XPINF;
		return x * y;
	endfunction

	function automatic longint div_round(longint n, longint d, bit up);
		longint q, r;
		q = n / d;
		r = n % d;
		if (!up && r != 0 && ((r < 0) != (d < 0))) q--;
		if (up && r != 0 && ((r < 0) == (d < 0))) q++;
		return q;
	endfunction

	function automatic longint divx(longint x, longint y, bit up);
		if (x == 0) return 0;
		if (infinite(x) && infinite(y)) return up ? XPINF : XNINF;
		if (infinite(x)) return ((x < 0) != (y < 0)) ? XNINF : XPINF;
		if (infinite(y)) return 0;
		return div_round(x * (64'sd1 <<< iau_pkg::FRAC_BITS), y, up);
	endfunction

	function automatic interval_res_t interval_eval(op_beat_t op);
		interval_res_t r;
		longint xl, xh, yl, yh, lo, hi, c;
		longint p[4], n[2], d[2];
		xl = widen(op.al);
		xh = widen(op.ah);
		yl = widen(op.bl);
		yh = widen(op.bh);
		lo = 0;
		hi = 0;
		r.truth = 1'b0;
		case (op.mode)
			iau_pkg::MODE_ADD: begin
				lo = addx(xl, yl, 0);
				hi = addx(xh, yh, 1);
			end
			iau_pkg::MODE_SUB: begin
				lo = addx(xl, negx(yh), 0);
				hi = addx(xh, negx(yl), 1);
			end
			iau_pkg::MODE_MUL: begin
				p[0] = mulx(xl, yl);
				p[1] = mulx(xl, yh);
				p[2] = mulx(xh, yl);
				p[3] = mulx(xh, yh);
				lo = p[0];
				hi = p[0];
				for (int k = 1; k < 4; k++) begin
					if (p[k] < lo) lo = p[k];
					if (p[k] > hi) hi = p[k];
				end
				if (!infinite(lo)) lo = lo >>> iau_pkg::FRAC_BITS;
				if (!infinite(hi)) hi = -((-hi) >>> iau_pkg::FRAC_BITS);
			end
			iau_pkg::MODE_DIV: begin
				if ((op.bl <= 0 && op.bh >= 0) || op.bl == 0 || op.bh == 0) begin
					lo = XNINF;
					hi = XPINF;
				end else begin
					n[0] = xl;
					n[1] = xh;
					d[0] = yl;
					d[1] = yh;
					lo = XPINF;
					hi = XNINF;
					for (int i = 0; i < 2; i++)
						for (int j = 0; j < 2; j++) begin
							c = divx(n[i], d[j], 0);
							if (c < lo) lo = c;
							c = divx(n[i], d[j], 1);
							if (c > hi) hi = c;
						end
				end
			end
			iau_pkg::MODE_NEG: begin
				lo = negx(xh);
				hi = negx(xl);
			end
			iau_pkg::MODE_CONS: r.truth = op.al <= op.ah;
			iau_pkg::MODE_CONST: r.truth = op.al == op.ah;
			iau_pkg::MODE_ISECT: r.truth = op.ah >= op.bl && op.al <= op.bh;
			iau_pkg::MODE_CONTAIN: r.truth = op.al <= op.bl && op.ah >= op.bh;
			iau_pkg::MODE_DISJ: r.truth = op.ah < op.bl || op.al > op.bh;
			iau_pkg::MODE_LT: r.truth = op.ah < op.bl;
			iau_pkg::MODE_LE: r.truth = op.ah <= op.bl;
			iau_pkg::MODE_EQ: r.truth = op.al == op.ah && op.bl == op.bh && op.al == op.bl;
			iau_pkg::MODE_GE: r.truth = op.al >= op.bh;
			iau_pkg::MODE_GT: r.truth = op.al > op.bh;
			default: ;
		endcase
		if (op.mode <= iau_pkg::MODE_NEG) begin
			r.lo = clamp(lo);
			r.hi = clamp(hi);
		end else begin
			r.lo = '0;
			r.hi = '0;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] rand_bound();
		case ($urandom_range(0, 9))
			0: return NINF;
			1: return PINF;
			2: return 32'($urandom_range(0, 8)) - 4;
			3: return (32'($urandom_range(0, 64)) - 32) * ONE;
			4, 5: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_beat_t rand_op();
		op_beat_t op;
		logic signed [31:0] t;
		op.mode = ($urandom_range(0, 49) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
		op.al = rand_bound();
		op.ah = rand_bound();
		op.bl = rand_bound();
		op.bh = ($urandom_range(0, 5) == 0) ? op.bl : rand_bound();
		if ($urandom_range(0, 9) > 0 && op.al > op.ah) begin
			t = op.al; op.al = op.ah; op.ah = t;
		end
		if ($urandom_range(0, 9) > 0 && op.bl > op.bh) begin
			t = op.bl; op.bl = op.bh; op.bh = t;
		end
		return op;
	endfunction

	task automatic send_op(op_beat_t op, bit known, interval_res_t res);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		mode <= op.mode;
		a_lo <= op.al;
		a_hi <= op.ah;
		b_lo <= op.bl;
		b_hi <= op.bh;
		in_valid <= 1'b1;
		expected_q.push_back(known ? res : interval_eval(op));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				interval_res_t e;
				e = expected_q.pop_front();
				if (res_lo !== e.lo) begin
					$error("res_lo expected %h actual %h", e.lo, res_lo);
					errors++;
				end
				if (res_hi !== e.hi) begin
					$error("res_hi expected %h actual %h", e.hi, res_hi);
					errors++;
				end
				if (truth !== e.truth) begin
					$error("truth expected %b actual %b", e.truth, truth);
					errors++;
				end
			end
		end
		out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		vector_t vectors[$];
		interval_res_t none;
		none = '{lo: '0, hi: '0, truth: 1'b0};
		vectors = '{
			'{'{iau_pkg::MODE_ADD, ONE, 2*ONE, 3*ONE, 4*ONE}, 1, '{4*ONE, 6*ONE, 0}},
			'{'{iau_pkg::MODE_ADD, NINF, PINF, PINF, NINF}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_ADD, 32'sh7000_0000, PINF-1, 32'sh7000_0000, 1}, 1,
				'{PINF, PINF, 0}},
			'{'{iau_pkg::MODE_SUB, NINF, PINF, NINF, PINF}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_MUL, 0, 0, NINF, PINF}, 1, '{0, 0, 0}},
			'{'{iau_pkg::MODE_MUL, -ONE, 1, -1, 3}, 0, none},
			'{'{iau_pkg::MODE_MUL, NINF, PINF, -5, 7}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_DIV, ONE, 2*ONE, -ONE, ONE}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_DIV, ONE, 2*ONE, 0, 0}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_DIV, ONE, 2*ONE, ONE, 0}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_DIV, NINF, PINF, NINF, -ONE}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_DIV, ONE, 2*ONE, ONE, PINF}, 1, '{0, 2*ONE, 0}},
			'{'{iau_pkg::MODE_DIV, 1, 7, 3*ONE, 3*ONE}, 0, none},
			'{'{iau_pkg::MODE_DIV, PINF-1, PINF-1, 1, 1}, 1, '{PINF, PINF, 0}},
			'{'{iau_pkg::MODE_NEG, NINF, PINF, 0, 0}, 1, '{NINF, PINF, 0}},
			'{'{iau_pkg::MODE_CONS, 5, 4, 0, 0}, 1, '{0, 0, 0}},
			'{'{iau_pkg::MODE_CONST, 4, 4, 0, 0}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_ISECT, 0, 5, 5, 9}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_CONTAIN, NINF, PINF, 2, 3}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_DISJ, 0, 5, 5, 9}, 1, '{0, 0, 0}},
			'{'{iau_pkg::MODE_LT, NINF, 4, 5, 9}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_LE, 0, 5, 5, 9}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_EQ, PINF, PINF, PINF, PINF}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_GE, 5, 9, 0, 5}, 1, '{0, 0, 1}},
			'{'{iau_pkg::MODE_GT, 5, 9, 0, 5}, 1, '{0, 0, 0}},
			'{'{4'd15, NINF, PINF, 7, 7}, 1, '{0, 0, 0}}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vectors[i]) send_op(vectors[i].op, vectors[i].known, vectors[i].res);

		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int n = 0; n < 150; n++) send_op(rand_op(), 0, none);
		join
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 80 : 0;
			recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 19 : 0;
			for (int n = 0; n < 530; n++) send_op(rand_op(), 0, none);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

[interval_arithmetic_unit.f]
sv/iau_pkg.sv
sv/iau_front.sv
sv/iau_mul.sv
sv/iau_div_step.sv
sv/iau_div_fin.sv
sv/interval_arithmetic_unit.sv
dv/interval_arithmetic_unit_test.sv
